// ===== design/bism_pkg.sv =====
// bism_pkg: shared constants and a popcount function for the bitmap indexed sparse map
// no dependencies
`timescale 1ns / 1ps

package bism_pkg;

    localparam logic [1:0] MODE_GET    = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_KEY_ZERO = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int COUNT_BITS = 7;
    localparam int VALUE_PORT_BITS = 32;

    // popcount of one presence byte, done with the usual mask ladder
    function automatic logic [3:0] pop8(input logic [7:0] x);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        a = (x & 8'h55) + ((x >> 1) & 8'h55);
        b = (a & 8'h33) + ((a >> 2) & 8'h33);
        c = (b & 8'h0f) + ((b >> 4) & 8'h0f);
        return c[3:0];
    endfunction

endpackage

// ===== design/bism_values.sv =====
// bism_values: packed value memory, one write and one registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps

module bism_values #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bitmap_indexed_sparse_map.sv =====
// bitmap_indexed_sparse_map: top level, sequencer around the packed value memory
// depends on bism_pkg and bism_values
`timescale 1ns / 1ps
//
//  channel | signals                          | dir | meaning
//  in      | in_valid in_ready mode key value_in | in | one operation per beat
//  out     | out_valid out_ready status value_out entry_count | out | one result per beat
//
//  one item at a time; errors and the unused mode register the result directly from
//  the idle state, get reads through S_READ and S_GETW, overwrite runs the prefix sweep
//  insert and remove walk the packed entries past the slot, a read and a write state per
//  moved entry, then the prefix counts above the byte, one per cycle; the moves go
//  through the single memory port pair
//  reset clears presence bytes, prefix counts and count at once (flip-flops)
//  a waiting result blocks the next beat until it is taken

module bitmap_indexed_sparse_map #(
    parameter int FLAG_BYTES = 32,
    parameter int CAPACITY = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [7:0]                          key,
    input  logic [bism_pkg::VALUE_PORT_BITS-1:0] value_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [bism_pkg::VALUE_PORT_BITS-1:0] value_out,
    output logic [bism_pkg::COUNT_BITS-1:0]      entry_count
);
    import bism_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BW = (FLAG_BYTES > 1) ? $clog2(FLAG_BYTES) : 1;
    localparam int SW = 9;  // slot and walk index width, holds up to 255+8
    localparam int CW = 8;  // internal count width, holds up to 255
    localparam int VB = (VALUE_BITS < VALUE_PORT_BITS) ? VALUE_BITS : VALUE_PORT_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_GETW, S_UPRD, S_UPWR, S_DNRD, S_DNWR, S_PFX
    } state_t;

    // presence bytes and prefix counts, flip-flops with reset
    logic [7:0]            presence_reg [FLAG_BYTES];
    logic [CW-1:0]         prefix_reg   [FLAG_BYTES];
    logic [CW-1:0]         count_reg;

    state_t                state_reg;
    logic [1:0]            mode_reg;
    logic [BW-1:0]         byte_reg;
    logic [SW-1:0]         slot_reg;
    logic [SW-1:0]         walk_reg;
    logic [BW:0]           pfx_reg;
    logic                  up_reg;
    logic [VB-1:0]         val_reg;
    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [VALUE_PORT_BITS-1:0] vout_reg;

    // overwrite marker: set on an existing key leaves the prefix counts alone
    logic                  ovr_q;

    // memory ports
    logic          we;
    logic [AW-1:0] waddr;
    logic [VB-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [VB-1:0] rdata;

    bism_values #(.DEPTH(CAPACITY), .WIDTH(VB), .AW(AW)) u_values (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // lookup of the accepted key, done in the idle cycle
    logic [7:0]    km1;
    logic [7:0]    cur_bits;
    logic [7:0]    cur_bit;
    logic          present;
    logic [SW-1:0] slot;
    logic          in_range;
    logic [BW-1:0] bidx;

    always_comb
    begin
        km1      = key - 8'd1;
        in_range = ({3'd0, km1[7:3]} < 8'(FLAG_BYTES));
        bidx     = BW'(km1[7:3]);
        cur_bits = presence_reg[bidx];
        cur_bit  = 8'd1 << km1[2:0];
        present  = (cur_bits & cur_bit) != 8'd0;
        slot     = SW'(prefix_reg[bidx]) + SW'(pop8(cur_bits & (cur_bit - 8'd1)));
    end

    assign in_ready    = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_count = count_reg[COUNT_BITS-1:0];

    // memory drive from sequencer state
    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(slot_reg);
        wdata = val_reg;
        raddr = AW'(walk_reg);
        case (state_reg)
            S_READ:
            begin
                raddr = AW'(slot_reg);
            end
            S_UPRD:
            begin
                raddr = AW'(walk_reg - SW'(1));
            end
            S_UPWR:
            begin
                we    = 1'b1;
                waddr = AW'(walk_reg);
                wdata = rdata;
            end
            S_DNRD:
            begin
                raddr = AW'(walk_reg + SW'(1));
            end
            S_DNWR:
            begin
                we    = 1'b1;
                waddr = AW'(walk_reg);
                wdata = rdata;
            end
            S_PFX:
            begin
                // the value write on set happens on the first sweep cycle
                we = (mode_reg == MODE_SET) && up_reg && (pfx_reg == (BW+1)'(byte_reg) + 1'b1);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < FLAG_BYTES; i++)
            begin
                presence_reg[i] <= '0;
                prefix_reg[i]   <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg   <= mode;
                        byte_reg   <= bidx;
                        slot_reg   <= slot;
                        val_reg    <= value_in[VB-1:0];
                        vout_reg   <= '0;
                        pfx_reg    <= (BW+1)'(bidx) + 1'b1;
                        if (mode == MODE_UNUSED)
                        begin
                            status_reg    <= ST_OK;
                            out_valid_reg <= 1'b1;
                        end
                        else if (key == 8'd0)
                        begin
                            status_reg    <= ST_KEY_ZERO;
                            out_valid_reg <= 1'b1;
                        end
                        else if (!in_range)
                        begin
                            status_reg    <= ST_ABSENT;
                            out_valid_reg <= 1'b1;
                        end
                        else if (mode == MODE_GET)
                        begin
                            if (present && slot < SW'(CAPACITY))
                            begin
                                status_reg <= ST_OK;
                                state_reg  <= S_READ;
                            end
                            else
                            begin
                                status_reg    <= ST_ABSENT;
                                out_valid_reg <= 1'b1;
                            end
                        end
                        else if (mode == MODE_SET)
                        begin
                            if (present)
                            begin
                                // overwrite in place through the first sweep write
                                status_reg <= ST_OK;
                                up_reg     <= 1'b1;
                                if (slot < SW'(CAPACITY))
                                begin
                                    state_reg <= S_PFX;
                                end
                                else
                                begin
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            else if (count_reg >= CW'(CAPACITY)
                                     || slot >= SW'(CAPACITY))
                            begin
                                status_reg    <= ST_FULL;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                up_reg     <= 1'b1;
                                walk_reg   <= SW'(count_reg);
                                state_reg  <= S_UPRD;
                                presence_reg[bidx] <= cur_bits | cur_bit;
                                count_reg  <= count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            if (!present)
                            begin
                                status_reg    <= ST_ABSENT;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                up_reg     <= 1'b0;
                                walk_reg   <= slot;
                                state_reg  <= S_DNRD;
                                presence_reg[bidx] <= cur_bits & ~cur_bit;
                                if (count_reg != '0)
                                begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_GETW;
                end
                S_GETW:
                begin
                    vout_reg      <= VALUE_PORT_BITS'(rdata);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_UPRD:
                begin
                    // walk_reg is the destination, above the slot while shifting
                    if (walk_reg > slot_reg)
                    begin
                        state_reg <= S_UPWR;
                    end
                    else
                    begin
                        state_reg <= S_PFX;
                    end
                end
                S_UPWR:
                begin
                    walk_reg  <= walk_reg - SW'(1);
                    state_reg <= S_UPRD;
                end
                S_DNRD:
                begin
                    // count_reg already holds the count after removal
                    if (walk_reg < SW'(count_reg) && walk_reg + SW'(1) < SW'(CAPACITY))
                    begin
                        state_reg <= S_DNWR;
                    end
                    else
                    begin
                        state_reg <= S_PFX;
                    end
                end
                S_DNWR:
                begin
                    walk_reg  <= walk_reg + SW'(1);
                    state_reg <= S_DNRD;
                end
                S_PFX:
                begin
                    // one prefix count per cycle, bytes above the key's byte
                    if (pfx_reg < (BW+1)'(FLAG_BYTES))
                    begin
                        if (!ovr_q)
                        begin
                            if (up_reg)
                            begin
                                prefix_reg[BW'(pfx_reg)] <= prefix_reg[BW'(pfx_reg)] + 1'b1;
                            end
                            else if (prefix_reg[BW'(pfx_reg)] != '0)
                            begin
                                prefix_reg[BW'(pfx_reg)] <= prefix_reg[BW'(pfx_reg)] - 1'b1;
                            end
                        end
                        pfx_reg <= pfx_reg + 1'b1;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovr_q <= 1'b0;
        end
        else if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            ovr_q <= (mode == MODE_SET) && present;
        end
    end

endmodule

// ===== design/bism_checker.sv =====
// bism_checker: port level checks for the sparse map, bound to the top level
// depends on bism_pkg and bitmap_indexed_sparse_map
`timescale 1ns / 1ps

module bism_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [31:0] value_out,
    input logic [6:0] entry_count
);
    import bism_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out))
        else $error("result changed while stalled");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while one is in flight");

    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_KEY_ZERO |-> value_out == 32'd0)
        else $error("value on key zero error");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(out_valid) && !in_ready |=>
        entry_count == $past(entry_count) || entry_count == $past(entry_count) + 7'd1
        || entry_count + 7'd1 == $past(entry_count))
        else $error("count moved by more than one");

endmodule

bind bitmap_indexed_sparse_map bism_checker u_bism_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .value_out(value_out), .entry_count(entry_count)
);
